FILE: rtl/core/irc_pkg.sv
// ----------------------------------------------------------------------------
// irc_pkg
// Shared types, constants and register codes for the IR array centroid
// steering block.
// ----------------------------------------------------------------------------
package irc_pkg;

    localparam int NUM_RECEIVERS   = 15;
    localparam int ZONE_SIZE       = 5;
    localparam int COUNT_BITS      = 10;
    localparam int ANGLE_FRAC_BITS = 8;

    localparam int NUM_ZONES  = 3;
    localparam int ZONE_LEFT  = 0;
    localparam int ZONE_MID   = 1;
    localparam int ZONE_RIGHT = 2;

    localparam int IDX_W  = $clog2(NUM_RECEIVERS);
    localparam int POS_W  = $clog2(NUM_RECEIVERS + 1);
    localparam int ZPOS_W = (ZONE_SIZE > 1) ? $clog2(ZONE_SIZE) : 1;
    localparam int ZSEL_W = $clog2(NUM_ZONES + 1);
    localparam int ZONE_W = 3;

    localparam int SUM_W    = 14;
    localparam int WSUM_W   = 18;
    localparam int ANGLE_W  = 12;
    localparam int PWM_W    = 12;
    localparam int GAIN_W   = 10;
    localparam int MINSIG_W = 14;
    localparam int MID_W    = 3;

    localparam int PROD_W = COUNT_BITS + POS_W;
    localparam int SADD_W = ((SUM_W > COUNT_BITS) ? SUM_W : COUNT_BITS) + 1;
    localparam int WADD_W = ((WSUM_W > PROD_W) ? WSUM_W : PROD_W) + 1;
    localparam int NUM_W  = WSUM_W + ANGLE_FRAC_BITS;
    localparam int DCNT_W = $clog2(NUM_W + 1);

    localparam int ERR_W = ANGLE_W + 1;
    localparam int MUL_W = ERR_W + GAIN_W + 1;
    localparam int VAL_W = ((MUL_W > PWM_W + ANGLE_FRAC_BITS + 1) ?
                            MUL_W : PWM_W + ANGLE_FRAC_BITS + 1) + 2;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [ZONE_W-1:0]  ZONE_MAX  = '1;
    localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
    localparam logic [WSUM_W-1:0]  WSUM_MAX  = '1;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX = '1;

    localparam logic signed [MUL_W-1:0] MUL_RND = MUL_W'(2 ** ANGLE_FRAC_BITS - 1);
    localparam logic signed [VAL_W-1:0] VAL_RND = VAL_W'(2 ** ANGLE_FRAC_BITS - 1);

    localparam logic [PWM_W-1:0]    PWM_CENTER_RST  = PWM_W'(1500);
    localparam logic [GAIN_W-1:0]   PROP_GAIN_RST   = GAIN_W'(200);
    localparam logic [GAIN_W-1:0]   DERIV_GAIN_RST  = GAIN_W'(40);
    localparam logic [PWM_W-1:0]    PWM_MIN_RST     = PWM_W'(900);
    localparam logic [PWM_W-1:0]    PWM_MAX_RST     = PWM_W'(2100);
    localparam logic [ANGLE_W-1:0]  ANGLE_CENTER_RST = ANGLE_W'(2048);
    localparam logic [MINSIG_W-1:0] MIN_SIGNAL_RST  = MINSIG_W'(2);
    localparam logic [MID_W-1:0]    STRAIGHT_MID_RST = MID_W'(3);
    localparam logic [ANGLE_W-1:0]  ANGLE_PREV_RST  = ANGLE_W'(2048);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PWM_CENTER,
        REG_PROP_GAIN,
        REG_DERIV_GAIN,
        REG_PWM_MIN,
        REG_PWM_MAX,
        REG_ANGLE_CENTER,
        REG_MIN_SIGNAL,
        REG_STRAIGHT_MID
    } irc_cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_CLASS,
        ST_DIV,
        ST_PMUL,
        ST_DMUL,
        ST_SUM,
        ST_EMIT
    } irc_state_t;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  num;
        logic [SUM_W-1:0]  den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [NUM_W-1:0]  quot;
    } div_rsp_t;

endpackage

FILE: rtl/core/irc_in_if.sv
// ----------------------------------------------------------------------------
// irc_in_if
// Receiver item channel: one hit flag and pulse count per item.
// ----------------------------------------------------------------------------
interface irc_in_if;
    import irc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [COUNT_BITS-1:0] pulse_count;

    modport source (output valid, output hit, output pulse_count, input ready);
    modport sink (input valid, input hit, input pulse_count, output ready);
endinterface

FILE: rtl/core/irc_out_if.sv
// ----------------------------------------------------------------------------
// irc_out_if
// Steering result channel: one item per completed frame.
// ----------------------------------------------------------------------------
interface irc_out_if;
    import irc_pkg::*;

    logic               valid;
    logic               ready;
    logic [PWM_W-1:0]   pwm_value;
    logic [ANGLE_W-1:0] angle_q8;
    logic               straight;
    logic               signal_lost;

    modport source (output valid, output pwm_value, output angle_q8, output straight,
                    output signal_lost, input ready);
    modport sink (input valid, input pwm_value, input angle_q8, input straight,
                  input signal_lost, output ready);
endinterface

FILE: rtl/core/irc_cfg_if.sv
// ----------------------------------------------------------------------------
// irc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface irc_cfg_if;
    import irc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/irc_div.sv
// ----------------------------------------------------------------------------
// irc_div
// Restoring divider, one quotient bit per cycle, for the centroid angle.
// ----------------------------------------------------------------------------
module irc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  irc_pkg::div_req_t req,
    output irc_pkg::div_rsp_t rsp
);
    import irc_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [DCNT_W-1:0] step_reg;
    logic [SUM_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [SUM_W-1:0]  den_reg;

    logic [SUM_W:0]    shifted;
    logic [SUM_W:0]    diff;
    logic              fits;

    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign fits    = shifted >= {1'b0, den_reg};
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg && req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= DCNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - DCNT_W'(1);
                if (step_reg == DCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.num;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[SUM_W-1:0] : shifted[SUM_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule

FILE: rtl/core/ir_array_centroid_steering_top.sv
// ----------------------------------------------------------------------------
// ir_array_centroid_steering_top
// Receiver array steering: strongest hit run centroid and a clamped
// proportional-derivative servo pulse, one result item per frame.
//
//   Channel | Direction | Item contents
//   din     | in        | hit, pulse_count (one receiver)
//   dout    | out       | pwm_value, angle_q8, straight, signal_lost
//   cfg     | in        | index, data (always ready)
//
// Each receiver item is accepted, then multiplied and accumulated.
// The last item of a frame then passes through classification, the
// restoring divider (26 quotient bits and a done flag) when a centroid is
// needed, and the shared multiplier, summing and clamping steps.
// The output register holds a result while the next frame streams in; a
// new result waits in the last step until the previous one is taken.
// Reset loads the default register values and clears the frame state.
// ----------------------------------------------------------------------------
module ir_array_centroid_steering_top (
    input  logic       clk,
    input  logic       rst_n,
    irc_in_if.sink     din,
    irc_out_if.source  dout,
    irc_cfg_if.sink    cfg
);
    import irc_pkg::*;

    irc_state_t state_reg;
    irc_state_t state_next;

    logic [PWM_W-1:0]    pwm_center_reg;
    logic [GAIN_W-1:0]   prop_gain_reg;
    logic [GAIN_W-1:0]   deriv_gain_reg;
    logic [PWM_W-1:0]    pwm_min_reg;
    logic [PWM_W-1:0]    pwm_max_reg;
    logic [ANGLE_W-1:0]  center_reg;
    logic [MINSIG_W-1:0] min_sig_reg;
    logic [MID_W-1:0]    mid_count_reg;

    logic                  hit_item_reg;
    logic [COUNT_BITS-1:0] cnt_item_reg;

    logic [IDX_W-1:0]   idx_reg;
    logic [ZPOS_W-1:0]  zone_pos_reg;
    logic [ZSEL_W-1:0]  zone_sel_reg;
    logic [ZONE_W-1:0]  zone_hits_reg [NUM_ZONES];
    logic [SUM_W-1:0]   run_sum_reg;
    logic [WSUM_W-1:0]  run_w_reg;
    logic [SUM_W-1:0]   best_sum_reg;
    logic [WSUM_W-1:0]  best_w_reg;
    logic [ANGLE_W-1:0] angle_prev_reg;

    logic [ANGLE_W-1:0]       angle_reg;
    logic                     straight_reg;
    logic                     lost_reg;
    logic signed [MUL_W-1:0]  prod_reg;
    logic signed [MUL_W-1:0]  p_reg;
    logic signed [VAL_W-1:0]  v_reg;

    logic               out_valid_reg;
    logic [PWM_W-1:0]   out_pwm_reg;
    logic [ANGLE_W-1:0] out_angle_reg;
    logic               out_straight_reg;
    logic               out_lost_reg;

    logic in_ready_c;
    logic mul_deriv_c;
    logic div_start_c;

    logic              last_item;
    logic              emit_go;
    logic [POS_W-1:0]  pos_c;
    logic [PROD_W-1:0] acc_prod;
    logic [SADD_W-1:0] rs_sum;
    logic [WADD_W-1:0] rw_sum;
    logic [SUM_W-1:0]  rs_new;
    logic [WSUM_W-1:0] rw_new;

    logic lost_c;
    logic straight_c;
    logic weak_c;
    logic need_div;

    logic [ANGLE_W-1:0] quot_sat;

    logic signed [ERR_W-1:0]  err_c;
    logic signed [ERR_W-1:0]  dang_c;
    logic signed [ERR_W-1:0]  mul_a;
    logic [GAIN_W-1:0]        mul_b;
    logic signed [MUL_W-1:0]  mul_p;
    logic signed [MUL_W-1:0]  p_adj;
    logic signed [MUL_W-1:0]  p_c;
    logic signed [VAL_W-1:0]  base_c;
    logic signed [VAL_W-1:0]  val_c;
    logic signed [VAL_W-1:0]  val_adj;
    logic signed [VAL_W-1:0]  v_c;
    logic signed [VAL_W-1:0]  max_s;
    logic signed [VAL_W-1:0]  min_s;
    logic [PWM_W-1:0]         pwm_c;

    div_req_t div_req;
    div_rsp_t div_rsp;

    irc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_center_reg <= PWM_CENTER_RST;
            prop_gain_reg  <= PROP_GAIN_RST;
            deriv_gain_reg <= DERIV_GAIN_RST;
            pwm_min_reg    <= PWM_MIN_RST;
            pwm_max_reg    <= PWM_MAX_RST;
            center_reg     <= ANGLE_CENTER_RST;
            min_sig_reg    <= MIN_SIGNAL_RST;
            mid_count_reg  <= STRAIGHT_MID_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_PWM_CENTER:   pwm_center_reg <= cfg.data[PWM_W-1:0];
                REG_PROP_GAIN:    prop_gain_reg  <= cfg.data[GAIN_W-1:0];
                REG_DERIV_GAIN:   deriv_gain_reg <= cfg.data[GAIN_W-1:0];
                REG_PWM_MIN:      pwm_min_reg    <= cfg.data[PWM_W-1:0];
                REG_PWM_MAX:      pwm_max_reg    <= cfg.data[PWM_W-1:0];
                REG_ANGLE_CENTER: center_reg     <= cfg.data[ANGLE_W-1:0];
                REG_MIN_SIGNAL:   min_sig_reg    <= cfg.data[MINSIG_W-1:0];
                REG_STRAIGHT_MID: mid_count_reg  <= cfg.data[MID_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign last_item = idx_reg == IDX_W'(NUM_RECEIVERS - 1);
    assign emit_go   = !out_valid_reg || dout.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (din.valid)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:   state_next = last_item ? ST_CLASS : ST_IDLE;
            ST_CLASS: state_next = need_div ? ST_DIV : ST_PMUL;
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_PMUL;
                end
            end
            ST_PMUL:  state_next = ST_DMUL;
            ST_DMUL:  state_next = ST_SUM;
            ST_SUM:   state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready_c  = 1'b0;
        mul_deriv_c = 1'b0;
        div_start_c = 1'b0;
        case (state_reg)
            ST_IDLE:  in_ready_c  = 1'b1;
            ST_CLASS: div_start_c = need_div;
            ST_DMUL:  mul_deriv_c = 1'b1;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign din.ready = in_ready_c;

    always_ff @(posedge clk)
    begin
        if (din.valid && in_ready_c)
        begin
            hit_item_reg <= din.hit;
            cnt_item_reg <= din.pulse_count;
        end
    end

    assign pos_c    = POS_W'(idx_reg) + POS_W'(1);
    assign acc_prod = PROD_W'(cnt_item_reg) * PROD_W'(pos_c);
    assign rs_sum   = SADD_W'(run_sum_reg) + SADD_W'(cnt_item_reg);
    assign rw_sum   = WADD_W'(run_w_reg) + WADD_W'(acc_prod);
    assign rs_new   = (rs_sum > SADD_W'(SUM_MAX)) ? SUM_MAX : rs_sum[SUM_W-1:0];
    assign rw_new   = (rw_sum > WADD_W'(WSUM_MAX)) ? WSUM_MAX : rw_sum[WSUM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            zone_pos_reg   <= '0;
            zone_sel_reg   <= '0;
            run_sum_reg    <= '0;
            run_w_reg      <= '0;
            best_sum_reg   <= '0;
            best_w_reg     <= '0;
            angle_prev_reg <= ANGLE_PREV_RST;
            for (int z = 0; z < NUM_ZONES; z++)
            begin
                zone_hits_reg[z] <= '0;
            end
        end
        else if (state_reg == ST_ACC)
        begin
            if (hit_item_reg)
            begin
                run_sum_reg <= rs_new;
                run_w_reg   <= rw_new;
                if (rs_new > best_sum_reg)
                begin
                    best_sum_reg <= rs_new;
                    best_w_reg   <= rw_new;
                end
                for (int z = 0; z < NUM_ZONES; z++)
                begin
                    if (zone_sel_reg == ZSEL_W'(z) && zone_hits_reg[z] != ZONE_MAX)
                    begin
                        zone_hits_reg[z] <= zone_hits_reg[z] + ZONE_W'(1);
                    end
                end
            end
            else
            begin
                run_sum_reg <= '0;
                run_w_reg   <= '0;
            end
            if (!last_item)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
                if (zone_pos_reg == ZPOS_W'(ZONE_SIZE - 1))
                begin
                    zone_pos_reg <= '0;
                    if (zone_sel_reg != ZSEL_W'(NUM_ZONES))
                    begin
                        zone_sel_reg <= zone_sel_reg + ZSEL_W'(1);
                    end
                end
                else
                begin
                    zone_pos_reg <= zone_pos_reg + ZPOS_W'(1);
                end
            end
        end
        else if (state_reg == ST_EMIT && emit_go)
        begin
            idx_reg        <= '0;
            zone_pos_reg   <= '0;
            zone_sel_reg   <= '0;
            run_sum_reg    <= '0;
            run_w_reg      <= '0;
            best_sum_reg   <= '0;
            best_w_reg     <= '0;
            angle_prev_reg <= angle_reg;
            for (int z = 0; z < NUM_ZONES; z++)
            begin
                zone_hits_reg[z] <= '0;
            end
        end
    end

    assign lost_c = zone_hits_reg[ZONE_LEFT] <= ZONE_W'(1) &&
                    zone_hits_reg[ZONE_MID] == '0 &&
                    zone_hits_reg[ZONE_RIGHT] <= ZONE_W'(1);
    assign straight_c = int'(zone_hits_reg[ZONE_LEFT]) >= ZONE_SIZE &&
                        zone_hits_reg[ZONE_MID] == mid_count_reg &&
                        int'(zone_hits_reg[ZONE_RIGHT]) >= ZONE_SIZE;
    assign weak_c   = best_sum_reg == '0 || best_sum_reg < min_sig_reg;
    assign need_div = !lost_c && !straight_c && !weak_c;

    assign div_req.start = div_start_c;
    assign div_req.num   = {best_w_reg, {ANGLE_FRAC_BITS{1'b0}}};
    assign div_req.den   = best_sum_reg;

    assign quot_sat = (|div_rsp.quot[NUM_W-1:ANGLE_W]) ? ANGLE_MAX
                                                        : div_rsp.quot[ANGLE_W-1:0];

    assign err_c  = $signed({1'b0, angle_reg}) - $signed({1'b0, center_reg});
    assign dang_c = $signed({1'b0, angle_reg}) - $signed({1'b0, angle_prev_reg});
    assign mul_a  = mul_deriv_c ? dang_c : err_c;
    assign mul_b  = mul_deriv_c ? deriv_gain_reg : prop_gain_reg;
    assign mul_p  = MUL_W'(mul_a) * MUL_W'($signed({1'b0, mul_b}));

    assign p_adj = prod_reg + (prod_reg[MUL_W-1] ? MUL_RND : '0);
    assign p_c   = p_adj >>> ANGLE_FRAC_BITS;

    assign base_c  = VAL_W'($signed({1'b0, pwm_center_reg})) - VAL_W'(p_reg);
    assign val_c   = (base_c <<< ANGLE_FRAC_BITS) + VAL_W'(prod_reg);
    assign val_adj = val_c + (val_c[VAL_W-1] ? VAL_RND : '0);
    assign v_c     = val_adj >>> ANGLE_FRAC_BITS;

    assign max_s = VAL_W'($signed({1'b0, pwm_max_reg}));
    assign min_s = VAL_W'($signed({1'b0, pwm_min_reg}));
    assign pwm_c = (v_reg >= max_s) ? pwm_max_reg :
                   (v_reg <= min_s) ? pwm_min_reg : v_reg[PWM_W-1:0];

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_CLASS:
            begin
                lost_reg     <= lost_c;
                straight_reg <= !lost_c && straight_c;
                angle_reg    <= lost_c ? angle_prev_reg : center_reg;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    angle_reg <= quot_sat;
                end
            end
            ST_PMUL:
            begin
                prod_reg <= mul_p;
            end
            ST_DMUL:
            begin
                p_reg    <= p_c;
                prod_reg <= mul_p;
            end
            ST_SUM:
            begin
                v_reg <= v_c;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_EMIT && emit_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (dout.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT && emit_go)
        begin
            out_pwm_reg      <= pwm_c;
            out_angle_reg    <= angle_reg;
            out_straight_reg <= straight_reg;
            out_lost_reg     <= lost_reg;
        end
    end

    assign dout.valid       = out_valid_reg;
    assign dout.pwm_value   = out_pwm_reg;
    assign dout.angle_q8    = out_angle_reg;
    assign dout.straight    = out_straight_reg;
    assign dout.signal_lost = out_lost_reg;

endmodule

FILE: rtl/core/irc_checker.sv
// ----------------------------------------------------------------------------
// irc_checker
// Port-level checks for the steering block, attached to the top level.
// ----------------------------------------------------------------------------
module irc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [irc_pkg::PWM_W-1:0]   pwm_value,
    input logic [irc_pkg::ANGLE_W-1:0] angle_q8,
    input logic                        straight,
    input logic                        signal_lost
);
    import irc_pkg::*;

    // A result item stays offered until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped before it was taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(pwm_value) && $stable(angle_q8) &&
            $stable(straight) && $stable(signal_lost))
        else $error("stalled result item changed");

    // Every receiver item needs an accumulate step before the next one.
    a_item_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after an accepted item");

    a_class_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(straight && signal_lost))
        else $error("frame classified as both straight and lost");

endmodule

bind ir_array_centroid_steering_top irc_checker u_irc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (din.valid),
    .in_ready    (din.ready),
    .out_valid   (dout.valid),
    .out_ready   (dout.ready),
    .pwm_value   (dout.pwm_value),
    .angle_q8    (dout.angle_q8),
    .straight    (dout.straight),
    .signal_lost (dout.signal_lost)
);
